// ----- hw/rtl/bfcm_pkg.sv -----
// Package for the buffer frame clock manager: request and result types,
// command and status codes, and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none
package bfcm_pkg;
  localparam int NumFrames = 16;
  localparam int IdxW = 4;

  localparam logic [2:0] CmdRead = 3'd0;
  localparam logic [2:0] CmdUnpin = 3'd1;
  localparam logic [2:0] CmdAlloc = 3'd2;
  localparam logic [2:0] CmdDispose = 3'd3;
  localparam logic [2:0] CmdFlush = 3'd4;

  localparam logic [2:0] StHit = 3'd0;
  localparam logic [2:0] StLoaded = 3'd1;
  localparam logic [2:0] StOk = 3'd2;
  localparam logic [2:0] StAbsent = 3'd3;
  localparam logic [2:0] StFull = 3'd4;
  localparam logic [2:0] StNotPinned = 3'd5;
  localparam logic [2:0] StPinned = 3'd6;
  localparam logic [2:0] StNotFound = 3'd7;

  localparam logic [2:0] OpNone = 3'd0;
  localparam logic [2:0] OpHit = 3'd1;
  localparam logic [2:0] OpUnpin = 3'd2;
  localparam logic [2:0] OpClear = 3'd3;
  localparam logic [2:0] OpLoad = 3'd4;
  localparam logic [2:0] OpRefClr = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] file_id;
    logic [31:0] page_no;
    logic dirty_flag;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] frame_index;
    logic fetch_needed;
    logic writeback;
    logic [7:0] wb_file;
    logic [31:0] wb_page;
    logic last;
  } rsp_t;

  typedef struct packed {
    logic [2:0] op;
    logic [IdxW-1:0] idx;
    logic dirty;
    logic hand_we;
  } dp_cmd_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic pinned;
    logic refb;
    logic dirty;
    logic file_eq;
    logic any_free;
    logic [7:0] file;
    logic [31:0] page;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bfcm_datapath.sv -----
// Frame table datapath: tags, pin counts, reference and dirty bits, clock hand.
// Executes one table operation per cycle at an index chosen by the controller.
// Depends on bfcm_pkg.
`default_nettype none
module bfcm_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bfcm_pkg::req_t req,
  input  wire logic [bfcm_pkg::IdxW-1:0] probe,
  input  wire bfcm_pkg::dp_cmd_t dcmd,
  output bfcm_pkg::dp_stat_t stat,
  output logic [bfcm_pkg::IdxW-1:0] hand
);
  logic [bfcm_pkg::NumFrames-1:0] valid;
  logic [bfcm_pkg::NumFrames-1:0] refb;
  logic [bfcm_pkg::NumFrames-1:0] dirty;
  logic [7:0] pin [bfcm_pkg::NumFrames];
  logic [7:0] file [bfcm_pkg::NumFrames];
  logic [31:0] page [bfcm_pkg::NumFrames];
  logic [bfcm_pkg::NumFrames-1:0] free;

  always_comb begin
    for (int i = 0; i < bfcm_pkg::NumFrames; i++) free[i] = (pin[i] == 8'd0);
    stat.valid = valid[probe];
    stat.file_eq = file[probe] == req.file_id;
    stat.match = valid[probe] && stat.file_eq && page[probe] == req.page_no;
    stat.pinned = pin[probe] != 8'd0;
    stat.refb = refb[probe];
    stat.dirty = dirty[probe];
    stat.any_free = |free;
    stat.file = file[probe];
    stat.page = page[probe];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      refb <= '0;
      dirty <= '0;
      hand <= bfcm_pkg::IdxW'(bfcm_pkg::NumFrames - 1);
      for (int i = 0; i < bfcm_pkg::NumFrames; i++) pin[i] <= 8'd0;
    end else begin
      if (dcmd.hand_we) hand <= dcmd.idx;
      case (dcmd.op)
        bfcm_pkg::OpHit: begin
          if (pin[dcmd.idx] != 8'hff) pin[dcmd.idx] <= pin[dcmd.idx] + 8'd1;
          refb[dcmd.idx] <= 1'b1;
        end
        bfcm_pkg::OpUnpin: begin
          pin[dcmd.idx] <= pin[dcmd.idx] - 8'd1;
          if (dcmd.dirty) dirty[dcmd.idx] <= 1'b1;
        end
        bfcm_pkg::OpClear: begin
          valid[dcmd.idx] <= 1'b0;
          pin[dcmd.idx] <= 8'd0;
          refb[dcmd.idx] <= 1'b0;
          dirty[dcmd.idx] <= 1'b0;
        end
        bfcm_pkg::OpLoad: begin
          valid[dcmd.idx] <= 1'b1;
          file[dcmd.idx] <= req.file_id;
          page[dcmd.idx] <= req.page_no;
          pin[dcmd.idx] <= 8'd1;
          refb[dcmd.idx] <= 1'b1;
          dirty[dcmd.idx] <= 1'b0;
        end
        bfcm_pkg::OpRefClr: refb[dcmd.idx] <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bfcm_ctrl.sv -----
// Request sequencer: lookup scan, clock sweep and flush walk, one frame a cycle
// if not stalled. Drives the datapath, builds each result. Depends on bfcm_pkg.
`default_nettype none
module bfcm_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire bfcm_pkg::req_t in_req,
  output bfcm_pkg::req_t req,
  output logic out_valid,
  input  wire logic out_stall,
  output bfcm_pkg::rsp_t rsp,
  output logic [bfcm_pkg::IdxW-1:0] probe,
  output bfcm_pkg::dp_cmd_t dcmd,
  input  wire bfcm_pkg::dp_stat_t stat,
  input  wire logic [bfcm_pkg::IdxW-1:0] hand
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SSweep = 2'd2;
  localparam logic [1:0] SFlush = 2'd3;
  localparam logic [bfcm_pkg::IdxW-1:0] LastIdx =
    bfcm_pkg::IdxW'(bfcm_pkg::NumFrames - 1);

  logic [1:0] state, state_next;
  logic [bfcm_pkg::IdxW-1:0] idx, idx_next;
  logic [bfcm_pkg::IdxW-1:0] hnext;
  logic emit;
  bfcm_pkg::rsp_t r;
  logic can_out;

  assign can_out = !out_valid || !out_stall;
  assign in_stall = state != SIdle;
  assign hnext = (hand == LastIdx) ? '0 : hand + 1'b1;
  assign probe = (state == SSweep) ? hnext : idx;

  always_comb begin
    state_next = state;
    idx_next = idx;
    dcmd = '0;
    emit = 1'b0;
    r = '0;
    r.last = 1'b1;
    r.frame_index = idx;
    unique case (state)
      SIdle: begin
        idx_next = '0;
        if (in_valid) begin
          if (in_req.cmd == bfcm_pkg::CmdFlush) state_next = SFlush;
          else if (in_req.cmd <= bfcm_pkg::CmdDispose) state_next = SScan;
        end
      end
      SScan: if (can_out) begin
        if (stat.match) begin
          emit = 1'b1;
          state_next = SIdle;
          dcmd.idx = idx;
          case (req.cmd)
            bfcm_pkg::CmdUnpin: begin
              if (stat.pinned) begin
                r.status = bfcm_pkg::StOk;
                dcmd.op = bfcm_pkg::OpUnpin;
                dcmd.dirty = req.dirty_flag;
              end else r.status = bfcm_pkg::StNotPinned;
            end
            bfcm_pkg::CmdDispose: begin
              r.status = bfcm_pkg::StOk;
              dcmd.op = bfcm_pkg::OpClear;
            end
            default: begin
              r.status = bfcm_pkg::StHit;
              dcmd.op = bfcm_pkg::OpHit;
            end
          endcase
        end else if (idx == LastIdx) begin
          r.frame_index = '0;
          case (req.cmd)
            bfcm_pkg::CmdUnpin: begin
              emit = 1'b1; r.status = bfcm_pkg::StAbsent; state_next = SIdle;
            end
            bfcm_pkg::CmdDispose: begin
              emit = 1'b1; r.status = bfcm_pkg::StNotFound; state_next = SIdle;
            end
            default: begin
              if (stat.any_free) state_next = SSweep;
              else begin
                emit = 1'b1; r.status = bfcm_pkg::StFull; state_next = SIdle;
              end
            end
          endcase
        end else idx_next = idx + 1'b1;
      end
      SSweep: if (can_out) begin
        dcmd.idx = hnext;
        dcmd.hand_we = 1'b1;
        if (!stat.pinned) begin
          if (stat.refb) dcmd.op = bfcm_pkg::OpRefClr;
          else begin
            dcmd.op = bfcm_pkg::OpLoad;
            emit = 1'b1;
            r.status = bfcm_pkg::StLoaded;
            r.frame_index = hnext;
            r.fetch_needed = req.cmd == bfcm_pkg::CmdRead;
            r.writeback = stat.valid && stat.dirty;
            r.wb_file = r.writeback ? stat.file : 8'd0;
            r.wb_page = r.writeback ? stat.page : 32'd0;
            state_next = SIdle;
          end
        end
      end
      SFlush: if (can_out) begin
        if (stat.valid && stat.file_eq) begin
          emit = 1'b1;
          if (stat.pinned) begin
            r.status = bfcm_pkg::StPinned;
            state_next = SIdle;
          end else begin
            r.status = bfcm_pkg::StOk;
            r.last = 1'b0;
            r.writeback = stat.dirty;
            r.wb_file = stat.dirty ? stat.file : 8'd0;
            r.wb_page = stat.dirty ? stat.page : 32'd0;
            dcmd.op = bfcm_pkg::OpClear;
            dcmd.idx = idx;
          end
        end
        if (state_next == SFlush) begin
          if (idx == LastIdx) begin
            if (!emit) begin
              emit = 1'b1;
              r = '0;
              r.status = bfcm_pkg::StOk;
              r.last = 1'b1;
              state_next = SIdle;
            end else state_next = SScan;
          end else idx_next = idx + 1'b1;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  // A flush that clears the last frame closes with its final result via SScan.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == SScan && req.cmd == bfcm_pkg::CmdFlush) begin
        if (can_out) begin
          state <= SIdle;
          out_valid <= 1'b1;
          rsp <= '{status: bfcm_pkg::StOk, frame_index: '0, fetch_needed: 1'b0,
                   writeback: 1'b0, wb_file: 8'd0, wb_page: 32'd0, last: 1'b1};
        end else out_valid <= out_valid;
      end else begin
        state <= state_next;
        idx <= idx_next;
        if (emit) begin
          out_valid <= 1'b1;
          rsp <= r;
        end else if (!out_stall) out_valid <= 1'b0;
      end
      if (state == SIdle && in_valid) req <= in_req;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/buffer_frame_clock_manager.sv -----
// Buffer frame manager with clock replacement and pin counts (top level).
// Channel in: req (cmd, file_id, page_no, dirty_flag) with in_valid and
// in_stall. Channel out: rsp (status, frame_index, fetch_needed, writeback,
// wb_file, wb_page, last) with out_valid and out_stall. A transfer happens
// when valid is high and stall is low.
// One request is handled at a time; in_stall is high while it is in work.
// Lookup scans the table one frame a cycle while no result waits under
// out_stall and stops at the first match. A read or allocate that misses
// then runs the clock sweep, one frame a cycle on the same terms, if any
// frame is unpinned, else it returns full. Flush walks the 16 frames and
// emits one result per cleared frame, plus a closing result; a pinned frame
// of its file stops it with a pinned result in place of the closing one.
// Results sit in an output register; while a result waits under out_stall the
// sequencer waits and the table is not changed.
// Synchronous reset empties the table, clears all pin counts and marks, and
// sets the clock hand to the last frame.
// Depends on bfcm_pkg, bfcm_ctrl and bfcm_datapath.
`default_nettype none
module buffer_frame_clock_manager (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire bfcm_pkg::req_t in_req,
  output logic out_valid,
  input  wire logic out_stall,
  output bfcm_pkg::rsp_t rsp
);
  bfcm_pkg::req_t req;
  bfcm_pkg::dp_cmd_t dcmd;
  bfcm_pkg::dp_stat_t stat;
  logic [bfcm_pkg::IdxW-1:0] probe;
  logic [bfcm_pkg::IdxW-1:0] hand;

  bfcm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .req(req), .out_valid(out_valid), .out_stall(out_stall),
    .rsp(rsp), .probe(probe), .dcmd(dcmd), .stat(stat), .hand(hand)
  );

  bfcm_datapath u_dp (
    .clk(clk), .rst(rst), .req(req), .probe(probe), .dcmd(dcmd),
    .stat(stat), .hand(hand)
  );
endmodule
`default_nettype wire
